### design/ordered_list_deque_macros.svh
// ---------------------------------------------------------------------------
// ordered_list_deque_macros.svh
// Assertion macros shared by the ordered list deque design files.
// ---------------------------------------------------------------------------
`ifndef ORDERED_LIST_DEQUE_MACROS_SVH
`define ORDERED_LIST_DEQUE_MACROS_SVH

`ifndef SYNTHESIS
// Check prop at every rising edge of clk, masked while rst is high.
`define ODL_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ordered_list_deque assertion failed");
// Check prop at every rising edge of clk, reset included.
`define ODL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ordered_list_deque assertion failed");
`else
`define ODL_ASSERT(lbl, clk, rst, prop)
`define ODL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### design/odl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// odl_pkg
// Operation and status codes and the per-cell control type of the deque.
// ---------------------------------------------------------------------------
package odl_pkg;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int OCOUNT_W = 5;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Move command for one cell of the chain.
  typedef struct packed {
    logic take_prev;  // shift toward the back: copy the front-side neighbor
    logic take_next;  // shift toward the front: copy the back-side neighbor
    logic load_value; // write the incoming value in place
  } cell_ctrl_t;

endpackage

### design/odl_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// odl_cell
// One entry of the deque chain; copies a neighbor or loads a new value.
// ---------------------------------------------------------------------------
module odl_cell (
  input  logic                                 clk,
  input  odl_pkg::cell_ctrl_t                  ctrl,
  input  logic signed [odl_pkg::VALUE_W-1:0]   prev_data,
  input  logic signed [odl_pkg::VALUE_W-1:0]   next_data,
  input  logic signed [odl_pkg::VALUE_W-1:0]   value,
  output logic signed [odl_pkg::VALUE_W-1:0]   data
);
  import odl_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.take_prev) begin
      data <= prev_data;
    end else if (ctrl.take_next) begin
      data <= next_data;
    end else if (ctrl.load_value) begin
      data <= value;
    end
  end

endmodule

### design/odl_ctrl.sv
`timescale 1ns / 1ps
`include "ordered_list_deque_macros.svh"
// ---------------------------------------------------------------------------
// odl_ctrl
// Entry count, status decode and move commands for every cell of the chain.
// ---------------------------------------------------------------------------
module odl_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  logic [odl_pkg::OP_W-1:0]          operation,
  input  logic [odl_pkg::POS_W-1:0]         slot_position,
  output logic [odl_pkg::STATUS_W-1:0]      status,
  output logic [$clog2(DEPTH+1)-1:0]        count,
  output odl_pkg::cell_ctrl_t               cell_ctrl [DEPTH]
);
  import odl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [CW-1:0] count_next;
  logic          is_empty;
  logic          is_full;
  logic          pos_ok;
  logic          do_ins_front;
  logic          do_ins_back;
  logic          do_del_front;
  logic          do_remove;
  logic [MW-1:0] pos_ext;

  assign is_empty = (count == '0);
  assign is_full  = (count == FULL_COUNT);
  assign pos_ext  = MW'(slot_position);
  assign pos_ok   = (slot_position != '0) && (pos_ext <= MW'(count));

  always_comb begin
    status       = ST_OK;
    count_next   = count;
    do_ins_front = 1'b0;
    do_ins_back  = 1'b0;
    do_del_front = 1'b0;
    do_remove    = 1'b0;
    case (operation)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          count_next   = count + CW'(1);
          do_ins_front = (operation == OP_INS_FRONT);
          do_ins_back  = (operation == OP_INS_BACK);
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          count_next   = count - CW'(1);
          do_del_front = (operation == OP_DEL_FRONT);
        end
      end
      OP_REMOVE: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          count_next = count - CW'(1);
          do_remove  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Each cell compares its own place against the count and the position.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cmd
    always_comb begin
      cell_ctrl[i].take_prev  = fire && do_ins_front;
      cell_ctrl[i].take_next  = fire && (do_del_front ||
                                (do_remove && (MW'(i + 1) >= pos_ext)));
      cell_ctrl[i].load_value = fire && do_ins_back && (count == CW'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  `ODL_ASSERT_ALWAYS(a_count_bound, clk, rst || (count <= FULL_COUNT))
  `ODL_ASSERT(a_full_holds, clk, rst,
    fire && (status == ST_FULL) |=> count == FULL_COUNT)
  `ODL_ASSERT(a_del_counts, clk, rst,
    fire && (status == ST_OK) && (operation == OP_DEL_BACK) |=>
    count == $past(count) - CW'(1))

endmodule

### design/ordered_list_deque.sv
`timescale 1ns / 1ps
`include "ordered_list_deque_macros.svh"
// ---------------------------------------------------------------------------
// ordered_list_deque
// Bounded ordered list of signed 32-bit values run as a double-ended queue.
// ---------------------------------------------------------------------------
// Each input transaction carries one operation: insert at the front or back,
// delete at the front or back, or remove the entry at a 1-based position.
// Every transaction returns exactly one result transaction with a status
// (ok, empty, position out of range, full), the entry count after the
// operation, an empty flag and the front and back values (zero when empty).
// Entries live in a chain of DEPTH cells, entry 0 at the front; a front
// insert, front delete or removal moves every affected cell by one place at
// once. The chain updates on the accepting edge and the result register then
// picks up the front and back cells; s_tready stays low until that result is
// loaded, so no new item is taken while one is pending. A finished result
// waits in the output register while the next item is taken. The reported
// count wraps modulo 32. Operation codes 5 to 7 change nothing and report
// the current state with status ok.
// ---------------------------------------------------------------------------
module ordered_list_deque #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: operation[2:0], item_value[34:3], slot_position[39:35]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // m_tdata: status[1:0], entry_count[6:2], list_empty[7],
  //          front_value[39:8], back_value[71:40]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata
);
  import odl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MW = (CW > OCOUNT_W) ? CW : OCOUNT_W;

  // Unpack the input transaction.
  logic [OP_W-1:0]           operation;
  logic signed [VALUE_W-1:0] item_value;
  logic [POS_W-1:0]          slot_position;

  assign operation     = s_tdata[2:0];
  assign item_value    = s_tdata[34:3];
  assign slot_position = s_tdata[39:35];

  logic                      fire;
  logic                      pending;
  logic                      out_free;
  logic                      load_out;
  logic [STATUS_W-1:0]       status;
  logic [STATUS_W-1:0]       status_held;
  logic [CW-1:0]             count;
  cell_ctrl_t                cell_ctrl [DEPTH];
  logic signed [VALUE_W-1:0] cell_data [DEPTH];

  assign s_tready = !pending;
  assign fire     = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign load_out = pending && out_free;

  odl_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .operation     (operation),
    .slot_position (slot_position),
    .status        (status),
    .count         (count),
    .cell_ctrl     (cell_ctrl)
  );

  // Chain of entry cells. The front cell takes the new value on a front
  // insert; the back cell refills from itself, beyond the count anyway.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] prev_data;
    logic signed [VALUE_W-1:0] next_data;

    if (i == 0) begin : g_front
      assign prev_data = item_value;
    end else begin : g_mid_prev
      assign prev_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign next_data = cell_data[i];
    end else begin : g_mid_next
      assign next_data = cell_data[i+1];
    end

    odl_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .prev_data (prev_data),
      .next_data (next_data),
      .value     (item_value),
      .data      (cell_data[i])
    );
  end

  // Result fields, taken from the chain after it has settled.
  logic                      now_empty;
  logic [AW-1:0]             back_idx;
  logic signed [VALUE_W-1:0] front_value;
  logic signed [VALUE_W-1:0] back_value;
  logic [OCOUNT_W-1:0]       entry_count;
  logic [MW-1:0]             count_ext;

  assign now_empty   = (count == '0);
  assign back_idx    = AW'(count - CW'(1));
  assign front_value = now_empty ? '0 : cell_data[0];
  assign back_value  = now_empty ? '0 : cell_data[back_idx];
  assign count_ext   = MW'(count);
  assign entry_count = count_ext[OCOUNT_W-1:0];

  // Hold the status of the accepted item until its result is loaded.
  always_ff @(posedge clk) begin
    if (fire) begin
      status_held <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (fire) begin
      pending <= 1'b1;
    end else if (load_out) begin
      pending <= 1'b0;
    end
  end

  // Output register: advance a waiting result when the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {back_value, front_value, now_empty, entry_count, status_held};
    end
  end

  `ODL_ASSERT(a_fire_pends, clk, rst, fire |=> pending && !s_tready)
  `ODL_ASSERT(a_blocked_holds, clk, rst,
    pending && m_tvalid && !m_tready |=> pending)
  `ODL_ASSERT(a_empty_zero, clk, rst,
    m_tvalid && m_tdata[7] |-> (m_tdata[39:8] == '0) && (m_tdata[71:40] == '0))

endmodule
